@@ rtl/core/pbr_pkg.sv @@
package pbr_pkg;

  // default depth of the section table
  localparam int DEF_MAX_SECTIONS = 16;

  // relocation entry layout: type in the top nibble, page offset in the low 12 bits
  localparam logic [3:0]  RELOC_TYPE_HIGHLOW = 4'd3;
  localparam int          PAGE_OFS_W         = 12;
  localparam logic [11:0] PAGE_OFS_MASK      = 12'h0FFF;

  // smallest legal block: the 8-byte header
  localparam logic [31:0] BLOCK_HDR_BYTES = 32'd8;

  // register reset values
  localparam logic [31:0] NEW_BASE_RST      = 32'h0000_0000;
  localparam logic [31:0] OLD_BASE_RST      = 32'h0040_0000;
  localparam logic [4:0]  SECTION_COUNT_RST = 5'd1;
  localparam logic [31:0] RELOC_DIR_RST     = 32'h0000_0000;

  // configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_NEW_BASE      = 2'd0,
    REG_OLD_BASE      = 2'd1,
    REG_SECTION_COUNT = 2'd2,
    REG_RELOC_DIR     = 2'd3
  } reg_idx_t;

  localparam int PADDR_W = 4;

  // input opcodes; code 3 is reserved and ignored
  typedef enum logic [1:0] {
    OP_LOAD_SECTION = 2'd0,
    OP_START        = 2'd1,
    OP_HALFWORD     = 2'd2
  } op_t;

  // parser phases
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_RVA_LO = 4'd1,
    PH_RVA_HI = 4'd2,
    PH_SZ_LO  = 4'd3,
    PH_SZ_HI  = 4'd4,
    PH_WALK   = 4'd5,
    PH_ENTRY  = 4'd6,
    PH_DONE   = 4'd7,
    PH_ERROR  = 4'd8
  } phase_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  section_index;
    logic [31:0] section_rva;
    logic [31:0] section_virtual_size;
    logic [31:0] section_raw_size;
    logic [31:0] section_raw_offset;
    logic [15:0] reloc_halfword;
  } in_item_t;

  typedef struct packed {
    logic        patch_valid;
    logic [31:0] patch_offset;
    logic [31:0] patch_addend;
    logic        done_res;
    logic        error;
  } out_item_t;

  // one section table row
  typedef struct packed {
    logic [31:0] base_rva;
    logic [31:0] extent;
    logic [31:0] raw_ptr;
  } sect_entry_t;

  // configuration registers as seen by the parser
  typedef struct packed {
    logic [31:0] new_base;
    logic [31:0] old_base;
    logic [4:0]  section_count;
    logic [31:0] reloc_dir_size;
  } cfg_regs_t;

endpackage

@@ rtl/core/pbr_sect_ram.sv @@
module pbr_sect_ram
  import pbr_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_SECTIONS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  sect_entry_t   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output sect_entry_t   rdata
);

  sect_entry_t mem [DEPTH];
  sect_entry_t rdata_r;

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/pbr_cfg_regs.sv @@
module pbr_cfg_regs
  import pbr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_regs_t          cfg
);

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;
  logic      wr_en;
  reg_idx_t  reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_NEW_BASE:      cfg_nxt.new_base       = pwdata;
        REG_OLD_BASE:      cfg_nxt.old_base       = pwdata;
        REG_SECTION_COUNT: cfg_nxt.section_count  = pwdata[4:0];
        REG_RELOC_DIR:     cfg_nxt.reloc_dir_size = pwdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.new_base       <= NEW_BASE_RST;
      cfg_r.old_base       <= OLD_BASE_RST;
      cfg_r.section_count  <= SECTION_COUNT_RST;
      cfg_r.reloc_dir_size <= RELOC_DIR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    case (reg_sel)
      REG_NEW_BASE:      prdata = cfg_r.new_base;
      REG_OLD_BASE:      prdata = cfg_r.old_base;
      REG_SECTION_COUNT: prdata = {27'd0, cfg_r.section_count};
      REG_RELOC_DIR:     prdata = cfg_r.reloc_dir_size;
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/pbr_parser.sv @@
module pbr_parser
  import pbr_pkg::*;
#(
  parameter int MAX_SECTIONS = DEF_MAX_SECTIONS,
  parameter int AW           = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_regs_t     cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_item_t      in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output out_item_t     out_data,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output sect_entry_t   ram_wdata,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr,
  input  sect_entry_t   ram_rdata
);

  localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
  localparam int CW    = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SECTIONS);

  phase_t        phase_r, phase_nxt;
  logic [31:0]   page_rva_r, page_rva_nxt;
  logic [31:0]   page_ptr_r, page_ptr_nxt;
  logic [31:0]   block_bytes_r, block_bytes_nxt;
  logic [30:0]   entries_left_r, entries_left_nxt;
  logic [31:0]   consumed_r, consumed_nxt;
  logic [AW-1:0] walk_idx_r, walk_idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic          out_free;
  logic          accept;
  logic          res_valid;
  out_item_t     res;
  logic [CW-1:0] sect_n;
  logic [32:0]   blk_sum;
  logic [31:0]   blk_sat;
  logic          blk_done;
  logic [31:0]   rva_diff;
  logic          below_first;
  logic          sect_hit;
  logic          walk_last;
  logic [31:0]   hdr_bytes;
  logic [30:0]   ent_dec;
  logic          is_patch;
  logic [31:0]   addend;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (phase_r != PH_WALK) && out_free;
  assign accept   = in_valid && in_ready;
  assign addend   = cfg.new_base - cfg.old_base;

  // sections actually searched
  assign sect_n = (CW'(cfg.section_count) > MAX_CNT) ? MAX_CNT : CW'(cfg.section_count);

  // block close: saturating byte count against the directory size
  assign blk_sum  = {1'b0, consumed_r} + {1'b0, block_bytes_r};
  assign blk_sat  = blk_sum[32] ? 32'hFFFF_FFFF : blk_sum[31:0];
  assign blk_done = blk_sat >= cfg.reloc_dir_size;

  // section compare on the row last read from the section table
  assign rva_diff    = page_rva_r - ram_rdata.base_rva;
  assign below_first = (walk_idx_r == '0) && (page_rva_r < ram_rdata.base_rva);
  assign sect_hit    = (CW'(walk_idx_r) < sect_n) && (page_rva_r >= ram_rdata.base_rva)
                       && (rva_diff < ram_rdata.extent);
  assign walk_last   = (CW'(walk_idx_r) + CW'(1)) >= sect_n;

  assign hdr_bytes = {in_data.reloc_halfword, block_bytes_r[15:0]};
  assign ent_dec   = entries_left_r - 31'd1;
  assign is_patch  = in_data.reloc_halfword[15:PAGE_OFS_W] == RELOC_TYPE_HIGHLOW;

  // section row from a load transaction
  assign ram_waddr = AW'(in_data.section_index);
  always_comb begin
    ram_wdata.base_rva = in_data.section_rva;
    ram_wdata.extent   = (in_data.section_virtual_size > in_data.section_raw_size) ?
                         in_data.section_virtual_size : in_data.section_raw_size;
    ram_wdata.raw_ptr  = in_data.section_raw_offset;
  end

  // next state and results
  always_comb begin
    phase_nxt        = phase_r;
    page_rva_nxt     = page_rva_r;
    page_ptr_nxt     = page_ptr_r;
    block_bytes_nxt  = block_bytes_r;
    entries_left_nxt = entries_left_r;
    consumed_nxt     = consumed_r;
    walk_idx_nxt     = walk_idx_r;
    res_valid        = 1'b0;
    res              = '0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_raddr        = '0;

    if (phase_r == PH_WALK) begin
      // one section row per cycle; finishing waits for a free output slot
      if (below_first || sect_hit) begin
        if (out_free) begin
          page_ptr_nxt = below_first ? page_rva_r : (ram_rdata.raw_ptr + rva_diff);
          if (entries_left_r != '0) begin
            phase_nxt = PH_ENTRY;
          end else begin
            consumed_nxt = blk_sat;
            if (blk_done) begin
              phase_nxt    = PH_DONE;
              res_valid    = 1'b1;
              res.done_res = 1'b1;
            end else begin
              phase_nxt = PH_RVA_LO;
            end
          end
        end
      end else if (walk_last) begin
        if (out_free) begin
          phase_nxt = PH_ERROR;
          res_valid = 1'b1;
          res.error = 1'b1;
        end
      end else begin
        ram_re       = 1'b1;
        ram_raddr    = walk_idx_r + AW'(1);
        walk_idx_nxt = walk_idx_r + AW'(1);
      end
    end else if (accept) begin
      case (in_data.opcode)
        OP_LOAD_SECTION: begin
          ram_we = (CW'(in_data.section_index) < MAX_CNT);
        end
        OP_START: begin
          page_rva_nxt     = '0;
          page_ptr_nxt     = '0;
          block_bytes_nxt  = '0;
          entries_left_nxt = '0;
          consumed_nxt     = '0;
          if (cfg.reloc_dir_size <= BLOCK_HDR_BYTES) begin
            phase_nxt    = PH_IDLE;
            res_valid    = 1'b1;
            res.done_res = 1'b1;
          end else begin
            phase_nxt = PH_RVA_LO;
          end
        end
        OP_HALFWORD: begin
          case (phase_r)
            PH_RVA_LO: begin
              page_rva_nxt = {16'd0, in_data.reloc_halfword};
              phase_nxt    = PH_RVA_HI;
            end
            PH_RVA_HI: begin
              page_rva_nxt = {in_data.reloc_halfword, page_rva_r[15:0]};
              phase_nxt    = PH_SZ_LO;
            end
            PH_SZ_LO: begin
              block_bytes_nxt = {16'd0, in_data.reloc_halfword};
              phase_nxt       = PH_SZ_HI;
            end
            PH_SZ_HI: begin
              block_bytes_nxt = hdr_bytes;
              if ((hdr_bytes < BLOCK_HDR_BYTES) || hdr_bytes[0]) begin
                phase_nxt = PH_ERROR;
                res_valid = 1'b1;
                res.error = 1'b1;
              end else begin
                // start the section walk at row zero
                entries_left_nxt = hdr_bytes[31:1] - 31'd4;
                phase_nxt        = PH_WALK;
                walk_idx_nxt     = '0;
                ram_re           = 1'b1;
                ram_raddr        = '0;
              end
            end
            PH_ENTRY: begin
              entries_left_nxt = ent_dec;
              if (is_patch) begin
                res_valid        = 1'b1;
                res.patch_valid  = 1'b1;
                res.patch_offset = page_ptr_r
                                   + {20'd0, in_data.reloc_halfword[11:0] & PAGE_OFS_MASK};
                res.patch_addend = addend;
              end
              if (ent_dec == '0) begin
                consumed_nxt = blk_sat;
                if (blk_done) begin
                  phase_nxt    = PH_DONE;
                  res_valid    = 1'b1;
                  res.done_res = 1'b1;
                end else begin
                  phase_nxt = PH_RVA_LO;
                end
              end
            end
            PH_ERROR: begin
              res_valid = 1'b1;
              res.error = 1'b1;
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      page_rva_r     <= '0;
      page_ptr_r     <= '0;
      block_bytes_r  <= '0;
      entries_left_r <= '0;
      consumed_r     <= '0;
      walk_idx_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      page_rva_r     <= page_rva_nxt;
      page_ptr_r     <= page_ptr_nxt;
      block_bytes_r  <= block_bytes_nxt;
      entries_left_r <= entries_left_nxt;
      consumed_r     <= consumed_nxt;
      walk_idx_r     <= walk_idx_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/core/pe_base_relocation_fixup.sv @@
// Base-relocation fixup engine: load the section table with load transactions, set the
// registers, send a start transaction, then stream the relocation directory one halfword
// per transaction; each HIGHLOW entry returns a patch request (file offset plus addend).
// Transactions are taken only while the output register is free. The halfword that
// completes a well-formed block header holds off the input while the page is translated:
// the table sits in a memory with one write port and a registered read port and is
// compared one row per cycle, from row zero until a row matches; a page that lies below
// the first section matches at row zero. With no match the walk covers the section count
// clipped to MAX_SECTIONS and taken as at least one, then reports an error; the walk also
// ends only once the output register is free. The section memory is not cleared at
// reset; only rows that were loaded may be referenced. A result is held in an output
// register, and the next transaction is taken while it waits if it is consumed.
module pe_base_relocation_fixup
  import pbr_pkg::*;
#(
  parameter int MAX_SECTIONS = DEF_MAX_SECTIONS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  cfg_regs_t     cfg;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  sect_entry_t   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  sect_entry_t   ram_rdata;

  // configuration registers
  pbr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // section table
  pbr_sect_ram #(
    .DEPTH (MAX_SECTIONS),
    .AW    (AW)
  ) u_sect_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // directory parser and translation walk
  pbr_parser #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .AW           (AW)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule
